// ----- design/directional_movement_index_top_assert.svh -----
// ----------------------------------------------------------------------------
// directional movement index assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef DIRECTIONAL_MOVEMENT_INDEX_TOP_ASSERT_SVH
`define DIRECTIONAL_MOVEMENT_INDEX_TOP_ASSERT_SVH

// same-cycle implication
`define DMI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dmi check failed");

// next-cycle implication
`define DMI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dmi sequence check failed");

`endif

// ----- design/dmi_pkg.sv -----
// ----------------------------------------------------------------------------
// dmi_pkg
// widths, constants, command codes and control structs of the adx block
// ----------------------------------------------------------------------------
`default_nettype none

package dmi_pkg;

  // field and state widths
  localparam int PRICE_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int SMOOTH_BITS   = 48;
  localparam int OUT_BITS      = 23;
  localparam int BAR_BITS      = 10;
  localparam int PERIOD_BITS   = 9;
  localparam int ALPHA_BITS    = 16;
  localparam int DX_TOTAL_BITS = 32;
  localparam int DI_BITS       = 40;
  localparam int PROD_BITS     = SMOOTH_BITS + ALPHA_BITS;

  // divider sizes
  localparam int DIV_N_BITS = 64;
  localparam int DIV_D_BITS = 48;
  localparam int STEP_BITS  = 7;

  localparam logic [STEP_BITS-1:0] STEPS_FULL  = STEP_BITS'(64);
  localparam logic [STEP_BITS-1:0] STEPS_RATIO = STEP_BITS'(OUT_BITS);
  localparam logic [STEP_BITS-1:0] STEPS_ADX   = STEP_BITS'(DX_TOTAL_BITS);

  // configuration
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA  = 1'b1;

  localparam logic [PERIOD_BITS-1:0] PERIOD_MIN   = PERIOD_BITS'(2);
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX   = PERIOD_BITS'(256);
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);
  localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET  = ALPHA_BITS'(4681);

  localparam logic [BAR_BITS-1:0] BAR_SAT   = BAR_BITS'(1023);
  localparam logic [OUT_BITS-1:0] HUNDRED_Q = OUT_BITS'(100 << FRAC_BITS);

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_MOVE,
    OP_ACCUM,
    OP_DIV_START,
    OP_DIV_WRITE,
    OP_SDIFF,
    OP_SMUL,
    OP_SWRITE,
    OP_NORM,
    OP_DXACC,
    OP_RESULT
  } op_e;

  // division jobs, in the order they run
  typedef enum logic [2:0] {
    JOB_RANGE_N,
    JOB_PLUS_N,
    JOB_MINUS_N,
    JOB_PLUS_DI,
    JOB_MINUS_DI,
    JOB_DX,
    JOB_ADX0
  } job_e;

  // smoothing targets
  typedef enum logic [1:0] {
    SM_RANGE,
    SM_PLUS,
    SM_MINUS,
    SM_ADX
  } sm_e;

  typedef struct packed {
    op_e  op;
    job_e job;
    sm_e  sm;
  } dmi_cmd_t;

  typedef struct packed {
    logic start;
    logic b_le_n;
    logic b_eq_n;
    logic b_ge_n;
    logic b_le_2n2;
    logic b_eq_2n1;
    logic div_busy;
    logic out_busy;
  } dmi_stat_t;

endpackage

`default_nettype wire

// ----- design/dmi_div.sv -----
// ----------------------------------------------------------------------------
// dmi_div
// shared radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dmi_div import dmi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIV_N_BITS-1:0] dividend_i,
  input  logic [DIV_D_BITS-1:0] divisor_i,
  input  logic [STEP_BITS-1:0]  steps_i,
  output logic                  busy_o,
  output logic [DIV_N_BITS-1:0] quot_o
);

  logic                  busy_q;
  logic [STEP_BITS-1:0]  cnt_q;
  logic [DIV_D_BITS-1:0] rem_q;
  logic [DIV_N_BITS-1:0] dq_q;
  logic [DIV_D_BITS-1:0] dvs_q;
  logic [DIV_D_BITS:0]   shifted;
  logic [DIV_D_BITS:0]   trial;
  logic                  ge;

  // one trial subtraction per step
  always_comb begin
    shifted = {rem_q, dq_q[DIV_N_BITS-1]};
    trial   = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_BITS'(1);
      if (cnt_q == STEP_BITS'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DIV_D_BITS'(dividend_i >> steps_i);
      dq_q  <= dividend_i << (STEP_BITS'(DIV_N_BITS) - steps_i);
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? trial[DIV_D_BITS-1:0] : shifted[DIV_D_BITS-1:0];
      dq_q  <= {dq_q[DIV_N_BITS-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dq_q;

endmodule

`default_nettype wire

// ----- design/dmi_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmi_ctrl
// sequencer that steps the datapath through the work of one bar
// ----------------------------------------------------------------------------
`default_nettype none

module dmi_ctrl import dmi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dmi_stat_t stat_i,
  output dmi_cmd_t  cmd_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MOVE     = 4'd1;
  localparam logic [3:0] ST_ACCUM    = 4'd2;
  localparam logic [3:0] ST_DIV_GO   = 4'd3;
  localparam logic [3:0] ST_DIV_WAIT = 4'd4;
  localparam logic [3:0] ST_SDIFF    = 4'd5;
  localparam logic [3:0] ST_SMUL     = 4'd6;
  localparam logic [3:0] ST_SWRITE   = 4'd7;
  localparam logic [3:0] ST_NORM     = 4'd8;
  localparam logic [3:0] ST_ADX      = 4'd9;
  localparam logic [3:0] ST_OUT      = 4'd10;

  logic [3:0] state_q, state_d;
  job_e       job_q, job_d;
  sm_e        sm_q, sm_d;
  dmi_cmd_t   cmd;

  // next state and command
  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    sm_d     = sm_q;
    cmd.op   = OP_NONE;
    cmd.job  = job_q;
    cmd.sm   = sm_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.op  = OP_CAPTURE;
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (stat_i.start) begin
          cmd.op  = OP_CLEAR;
          state_d = ST_OUT;
        end else begin
          cmd.op  = OP_MOVE;
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (stat_i.b_le_n) begin
          cmd.op = OP_ACCUM;
          if (stat_i.b_eq_n) begin
            job_d   = JOB_RANGE_N;
            state_d = ST_DIV_GO;
          end else begin
            state_d = ST_OUT;
          end
        end else begin
          sm_d    = SM_RANGE;
          state_d = ST_SDIFF;
        end
      end
      ST_DIV_GO: begin
        cmd.op  = OP_DIV_START;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!stat_i.div_busy) begin
          cmd.op = OP_DIV_WRITE;
          case (job_q)
            JOB_RANGE_N: begin
              job_d   = JOB_PLUS_N;
              state_d = ST_DIV_GO;
            end
            JOB_PLUS_N: begin
              job_d   = JOB_MINUS_N;
              state_d = ST_DIV_GO;
            end
            JOB_MINUS_N: begin
              state_d = ST_NORM;
            end
            JOB_PLUS_DI: begin
              job_d   = JOB_MINUS_DI;
              state_d = ST_DIV_GO;
            end
            JOB_MINUS_DI: begin
              job_d   = JOB_DX;
              state_d = ST_DIV_GO;
            end
            JOB_DX: begin
              state_d = ST_ADX;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_SDIFF: begin
        cmd.op  = OP_SDIFF;
        state_d = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.op  = OP_SMUL;
        state_d = ST_SWRITE;
      end
      ST_SWRITE: begin
        cmd.op = OP_SWRITE;
        case (sm_q)
          SM_RANGE: begin
            sm_d    = SM_PLUS;
            state_d = ST_SDIFF;
          end
          SM_PLUS: begin
            sm_d    = SM_MINUS;
            state_d = ST_SDIFF;
          end
          SM_MINUS: begin
            state_d = ST_NORM;
          end
          default: begin
            state_d = ST_OUT;
          end
        endcase
      end
      ST_NORM: begin
        cmd.op  = OP_NORM;
        job_d   = JOB_PLUS_DI;
        state_d = ST_DIV_GO;
      end
      ST_ADX: begin
        if (stat_i.b_le_2n2) begin
          cmd.op  = OP_DXACC;
          state_d = ST_OUT;
        end else if (stat_i.b_eq_2n1) begin
          job_d   = JOB_ADX0;
          state_d = ST_DIV_GO;
        end else begin
          sm_d    = SM_ADX;
          state_d = ST_SDIFF;
        end
      end
      ST_OUT: begin
        if (!stat_i.out_busy) begin
          cmd.op  = OP_RESULT;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_RANGE_N;
      sm_q    <= SM_RANGE;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      sm_q    <= sm_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

// ----- design/dmi_dp.sv -----
// ----------------------------------------------------------------------------
// dmi_dp
// bar state, running sums, smoothing multiplier, divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module dmi_dp import dmi_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dmi_cmd_t               cmd_i,
  output dmi_stat_t              stat_o,
  input  logic [PERIOD_BITS-1:0] period_i,
  input  logic [ALPHA_BITS-1:0]  alpha_i,
  input  logic [PRICE_BITS-1:0]  high_price_i,
  input  logic [PRICE_BITS-1:0]  low_price_i,
  input  logic [PRICE_BITS-1:0]  close_price_i,
  input  logic                   series_start_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [OUT_BITS-1:0]    plus_di_o,
  output logic [OUT_BITS-1:0]    minus_di_o,
  output logic [OUT_BITS-1:0]    adx_value_o,
  output logic                   di_valid_o,
  output logic                   adx_valid_o
);

  localparam int SHIFT_BITS = 4;
  localparam int DXW        = OUT_BITS + 7;

  // captured bar
  logic [PRICE_BITS-1:0] hi_q, lo_q, cl_q;
  logic                  start_q;

  // series state
  logic [PRICE_BITS-1:0]    last_high_q, last_low_q, last_close_q;
  logic [BAR_BITS-1:0]      bar_q;
  logic [PERIOD_BITS-1:0]   n_q;
  logic [SMOOTH_BITS-1:0]   rs_q, ps_q, ms_q;
  logic [DX_TOTAL_BITS-1:0] dx_total_q;
  logic [OUT_BITS-1:0]      adx_q;

  // per-bar working values
  logic [PRICE_BITS-1:0]  tr_q, pdm_q, mdm_q;
  logic [DI_BITS-1:0]     nt_q;
  logic [SMOOTH_BITS-1:0] np_q, nm_q;
  logic [OUT_BITS-1:0]    pdi_q, mdi_q, dx_q;
  logic [SMOOTH_BITS-1:0] sdiff_q;
  logic                   sdir_q;
  logic [PROD_BITS-1:0]   prod_q;

  // result register
  logic                out_valid_q;
  logic [OUT_BITS-1:0] res_pdi_q, res_mdi_q, res_adx_q;
  logic                res_div_q, res_adxv_q;

  // divider hookup
  logic                  div_start;
  logic [DIV_N_BITS-1:0] div_dvd;
  logic [DIV_D_BITS-1:0] div_dvs;
  logic [STEP_BITS-1:0]  div_steps;
  logic                  div_busy;
  logic [DIV_N_BITS-1:0] div_quot;

  // combinational helpers
  logic [PERIOD_BITS-1:0]     n_clamp;
  logic signed [PRICE_BITS:0] hs, ls, lcs, d1, d2, d3, trs, up, down;
  logic [PRICE_BITS-1:0]      tr_d, pdm_d, mdm_d;
  logic [BAR_BITS-1:0]        two_n;
  logic                       b_ge_n, b_le_2n2;
  logic [SMOOTH_BITS-1:0]     sm_s, sm_x, sm_new;
  logic [SMOOTH_BITS-1:0]     np100;
  logic [OUT_BITS-1:0]        dx_diff;
  logic [OUT_BITS:0]          dx_sum;
  logic [DXW-1:0]             dx_diff100;
  logic [SHIFT_BITS-1:0]      sh;

  // period clamp
  always_comb begin
    if (period_i < PERIOD_MIN) begin
      n_clamp = PERIOD_MIN;
    end else if (period_i > PERIOD_MAX) begin
      n_clamp = PERIOD_MAX;
    end else begin
      n_clamp = period_i;
    end
  end

  // true range and directional movement
  always_comb begin
    hs  = $signed({1'b0, hi_q});
    ls  = $signed({1'b0, lo_q});
    lcs = $signed({1'b0, last_close_q});
    d1  = hs - ls;
    d2  = hs - lcs;
    d3  = ls - lcs;
    if (d2 < 0) begin
      d2 = -d2;
    end
    if (d3 < 0) begin
      d3 = -d3;
    end
    trs = d1;
    if (d2 > trs) begin
      trs = d2;
    end
    if (d3 > trs) begin
      trs = d3;
    end
    tr_d  = trs[PRICE_BITS-1:0];
    up    = hs - $signed({1'b0, last_high_q});
    down  = $signed({1'b0, last_low_q}) - ls;
    pdm_d = (up > down && up > 0) ? up[PRICE_BITS-1:0] : '0;
    mdm_d = (down > up && down > 0) ? down[PRICE_BITS-1:0] : '0;
  end

  // bar position flags
  always_comb begin
    two_n           = BAR_BITS'({n_q, 1'b0});
    b_ge_n          = bar_q >= BAR_BITS'(n_q);
    b_le_2n2        = bar_q <= (two_n - BAR_BITS'(2));
    stat_o.start    = start_q;
    stat_o.b_le_n   = bar_q <= BAR_BITS'(n_q);
    stat_o.b_eq_n   = bar_q == BAR_BITS'(n_q);
    stat_o.b_ge_n   = b_ge_n;
    stat_o.b_le_2n2 = b_le_2n2;
    stat_o.b_eq_2n1 = bar_q == (two_n - BAR_BITS'(1));
    stat_o.div_busy = div_busy;
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  // smoothing operands
  always_comb begin
    case (cmd_i.sm)
      SM_RANGE: begin
        sm_s = rs_q;
        sm_x = SMOOTH_BITS'({tr_q, {FRAC_BITS{1'b0}}});
      end
      SM_PLUS: begin
        sm_s = ps_q;
        sm_x = SMOOTH_BITS'({pdm_q, {FRAC_BITS{1'b0}}});
      end
      SM_MINUS: begin
        sm_s = ms_q;
        sm_x = SMOOTH_BITS'({mdm_q, {FRAC_BITS{1'b0}}});
      end
      default: begin
        sm_s = SMOOTH_BITS'(adx_q);
        sm_x = SMOOTH_BITS'(dx_q);
      end
    endcase
    sm_new = sdir_q ? sm_s + prod_q[PROD_BITS-1:ALPHA_BITS]
                    : sm_s - prod_q[PROD_BITS-1:ALPHA_BITS];
  end

  // normalize shift so the range fits the di division
  always_comb begin
    sh = '0;
    for (int i = 0; i < SMOOTH_BITS - DI_BITS; i++) begin
      if (rs_q[DI_BITS + i]) begin
        sh = SHIFT_BITS'(i + 1);
      end
    end
  end

  // divider operands
  always_comb begin
    np100      = (cmd_i.job == JOB_PLUS_DI) ? np_q * SMOOTH_BITS'(100)
                                            : nm_q * SMOOTH_BITS'(100);
    dx_diff    = (pdi_q > mdi_q) ? pdi_q - mdi_q : mdi_q - pdi_q;
    dx_sum     = {1'b0, pdi_q} + {1'b0, mdi_q};
    dx_diff100 = DXW'(dx_diff) * DXW'(100);
    div_start  = (cmd_i.op == OP_DIV_START);
    case (cmd_i.job)
      JOB_RANGE_N: begin
        div_dvd   = {rs_q, {FRAC_BITS{1'b0}}};
        div_dvs   = DIV_D_BITS'(n_q);
        div_steps = STEPS_FULL;
      end
      JOB_PLUS_N: begin
        div_dvd   = {ps_q, {FRAC_BITS{1'b0}}};
        div_dvs   = DIV_D_BITS'(n_q);
        div_steps = STEPS_FULL;
      end
      JOB_MINUS_N: begin
        div_dvd   = {ms_q, {FRAC_BITS{1'b0}}};
        div_dvs   = DIV_D_BITS'(n_q);
        div_steps = STEPS_FULL;
      end
      JOB_PLUS_DI, JOB_MINUS_DI: begin
        div_dvd   = {np100, {FRAC_BITS{1'b0}}};
        div_dvs   = DIV_D_BITS'(nt_q);
        div_steps = STEPS_RATIO;
      end
      JOB_DX: begin
        div_dvd   = DIV_N_BITS'({dx_diff100, {FRAC_BITS{1'b0}}});
        div_dvs   = DIV_D_BITS'(dx_sum);
        div_steps = STEPS_RATIO;
      end
      default: begin
        div_dvd   = DIV_N_BITS'(dx_total_q);
        div_dvs   = DIV_D_BITS'(n_q - PERIOD_BITS'(1));
        div_steps = STEPS_ADX;
      end
    endcase
  end

  dmi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // series state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_high_q  <= '0;
      last_low_q   <= '0;
      last_close_q <= '0;
      bar_q        <= '0;
      n_q          <= PERIOD_RESET;
      rs_q         <= '0;
      ps_q         <= '0;
      ms_q         <= '0;
      dx_total_q   <= '0;
      adx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.op == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLEAR: begin
          last_high_q  <= hi_q;
          last_low_q   <= lo_q;
          last_close_q <= cl_q;
          bar_q        <= '0;
          n_q          <= n_clamp;
          rs_q         <= '0;
          ps_q         <= '0;
          ms_q         <= '0;
          dx_total_q   <= '0;
          adx_q        <= '0;
        end
        OP_MOVE: begin
          last_high_q  <= hi_q;
          last_low_q   <= lo_q;
          last_close_q <= cl_q;
          n_q          <= n_clamp;
          if (bar_q != BAR_SAT) begin
            bar_q <= bar_q + BAR_BITS'(1);
          end
        end
        OP_ACCUM: begin
          rs_q <= rs_q + SMOOTH_BITS'(tr_q);
          ps_q <= ps_q + SMOOTH_BITS'(pdm_q);
          ms_q <= ms_q + SMOOTH_BITS'(mdm_q);
        end
        OP_DIV_WRITE: begin
          case (cmd_i.job)
            JOB_RANGE_N: rs_q  <= div_quot[SMOOTH_BITS-1:0];
            JOB_PLUS_N:  ps_q  <= div_quot[SMOOTH_BITS-1:0];
            JOB_MINUS_N: ms_q  <= div_quot[SMOOTH_BITS-1:0];
            JOB_ADX0:    adx_q <= div_quot[OUT_BITS-1:0];
            default: ;
          endcase
        end
        OP_SWRITE: begin
          case (cmd_i.sm)
            SM_RANGE: rs_q  <= sm_new;
            SM_PLUS:  ps_q  <= sm_new;
            SM_MINUS: ms_q  <= sm_new;
            default:  adx_q <= sm_new[OUT_BITS-1:0];
          endcase
        end
        OP_DXACC: begin
          dx_total_q <= dx_total_q + DX_TOTAL_BITS'(dx_q);
        end
        default: ;
      endcase
    end
  end

  // working values and result payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        hi_q    <= high_price_i;
        lo_q    <= low_price_i;
        cl_q    <= close_price_i;
        start_q <= series_start_i;
      end
      OP_MOVE: begin
        tr_q  <= tr_d;
        pdm_q <= pdm_d;
        mdm_q <= mdm_d;
      end
      OP_SDIFF: begin
        sdir_q  <= sm_x >= sm_s;
        sdiff_q <= (sm_x >= sm_s) ? sm_x - sm_s : sm_s - sm_x;
      end
      OP_SMUL: begin
        prod_q <= PROD_BITS'(sdiff_q) * PROD_BITS'(alpha_i);
      end
      OP_NORM: begin
        nt_q <= DI_BITS'(rs_q >> sh);
        np_q <= ps_q >> sh;
        nm_q <= ms_q >> sh;
      end
      OP_DIV_WRITE: begin
        case (cmd_i.job)
          JOB_PLUS_DI: begin
            if (nt_q == '0) begin
              pdi_q <= '0;
            end else if (np_q >= SMOOTH_BITS'(nt_q)) begin
              pdi_q <= HUNDRED_Q;
            end else begin
              pdi_q <= div_quot[OUT_BITS-1:0];
            end
          end
          JOB_MINUS_DI: begin
            if (nt_q == '0) begin
              mdi_q <= '0;
            end else if (nm_q >= SMOOTH_BITS'(nt_q)) begin
              mdi_q <= HUNDRED_Q;
            end else begin
              mdi_q <= div_quot[OUT_BITS-1:0];
            end
          end
          JOB_DX: begin
            dx_q <= (dx_sum == '0) ? '0 : div_quot[OUT_BITS-1:0];
          end
          default: ;
        endcase
      end
      OP_RESULT: begin
        res_pdi_q  <= b_ge_n ? pdi_q : '0;
        res_mdi_q  <= b_ge_n ? mdi_q : '0;
        res_adx_q  <= (b_ge_n && !b_le_2n2) ? adx_q : '0;
        res_div_q  <= b_ge_n;
        res_adxv_q <= b_ge_n && !b_le_2n2;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign plus_di_o   = res_pdi_q;
  assign minus_di_o  = res_mdi_q;
  assign adx_value_o = res_adx_q;
  assign di_valid_o  = res_div_q;
  assign adx_valid_o = res_adxv_q;

endmodule

`default_nettype wire

// ----- design/directional_movement_index_top.sv -----
// ----------------------------------------------------------------------------
// directional_movement_index_top
// average directional index (+DI, -DI, ADX) over a stream of price bars
// ----------------------------------------------------------------------------
// One bar is taken at a time and gives one result. A series start bar only
// resets the series state and a bar before bar n only adds to the sums; bar n
// runs three divisions of the sums by n plus the di work; every later bar runs
// the three divisions (+DI, -DI, DX) on the single shared radix-2 divider, with
// bar 2n-1 adding a division for the adx start value and each later bar the
// adx smoothing. A new bar is accepted while the previous result still waits in
// the output register; the block then stalls before writing the next result
// until that one is taken. Period and alpha should be written through the
// config port only while the block is idle; the block itself does not enforce
// it.
`default_nettype none

`include "directional_movement_index_top_assert.svh"

module directional_movement_index_top import dmi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [PRICE_BITS-1:0]    high_price_i,
  input  logic [PRICE_BITS-1:0]    low_price_i,
  input  logic [PRICE_BITS-1:0]    close_price_i,
  input  logic                     series_start_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OUT_BITS-1:0]      plus_di_o,
  output logic [OUT_BITS-1:0]      minus_di_o,
  output logic [OUT_BITS-1:0]      adx_value_o,
  output logic                     di_valid_o,
  output logic                     adx_valid_o
);

  logic [PERIOD_BITS-1:0] period_q;
  logic [ALPHA_BITS-1:0]  alpha_q;
  dmi_cmd_t               cmd;
  dmi_stat_t              stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      alpha_q  <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PERIOD: period_q <= cfg_data_i[PERIOD_BITS-1:0];
        CFG_ALPHA:  alpha_q  <= cfg_data_i[ALPHA_BITS-1:0];
        default: ;
      endcase
    end
  end

  dmi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dmi_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .period_i       (period_q),
    .alpha_i        (alpha_q),
    .high_price_i   (high_price_i),
    .low_price_i    (low_price_i),
    .close_price_i  (close_price_i),
    .series_start_i (series_start_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .plus_di_o      (plus_di_o),
    .minus_di_o     (minus_di_o),
    .adx_value_o    (adx_value_o),
    .di_valid_o     (di_valid_o),
    .adx_valid_o    (adx_valid_o)
  );

  // checks
  `DMI_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `DMI_ASSERT_IMP(a_adx_needs_di, clk_i, rst_ni, out_valid_o && adx_valid_o, di_valid_o)
  `DMI_ASSERT_IMP(a_zero_before_di, clk_i, rst_ni, out_valid_o && !di_valid_o, plus_di_o == '0 && minus_di_o == '0 && adx_value_o == '0)
  `DMI_ASSERT_IMP(a_di_range, clk_i, rst_ni, out_valid_o && di_valid_o, plus_di_o <= HUNDRED_Q && minus_di_o <= HUNDRED_Q)

endmodule

`default_nettype wire

// ----- bench/dmi_checker.sv -----
// ----------------------------------------------------------------------------
// dmi_checker
// Watches the bar and result channels of the adx block and keeps its own
// copy of the bar history, running sums and register settings. Each accepted
// bar yields one predicted reading. Each accepted result is compared field
// by field with the oldest reading still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module dmi_checker import dmi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [PRICE_BITS-1:0]    high_price_i,
  input  logic [PRICE_BITS-1:0]    low_price_i,
  input  logic [PRICE_BITS-1:0]    close_price_i,
  input  logic                     series_start_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [OUT_BITS-1:0]      plus_di_i,
  input  logic [OUT_BITS-1:0]      minus_di_i,
  input  logic [OUT_BITS-1:0]      adx_value_i,
  input  logic                     di_valid_i,
  input  logic                     adx_valid_i,
  output int                       errors_o,
  output int                       pending_o
);

  localparam logic [63:0] MASK48   = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MASK23   = 64'h0000_0000_007F_FFFF;
  localparam logic [63:0] PCT_FULL = 64'd100 << FRAC_BITS;
  localparam logic [63:0] WIDE_TR  = 64'd1 << DI_BITS;

  typedef struct packed {
    logic [OUT_BITS-1:0] plus_di;
    logic [OUT_BITS-1:0] minus_di;
    logic [OUT_BITS-1:0] adx;
    logic                di_ok;
    logic                adx_ok;
  } reading_t;

  // register mirror
  logic [PERIOD_BITS-1:0] period_reg;
  logic [ALPHA_BITS-1:0]  alpha_reg;

  // bar history and running values
  logic [63:0] prev_high, prev_low, prev_close;
  logic [9:0]  bar_idx;
  logic [63:0] range_avg, plus_avg, minus_avg;
  logic [31:0] dx_sum;
  logic [63:0] adx_run;

  reading_t due_readings[$];

  assign pending_o = due_readings.size();

  // one wilder / ema step, step size floored toward the old value
  function automatic logic [63:0] ease(logic [63:0] s, logic [63:0] x);
    logic [63:0] a;
    a = {48'd0, alpha_reg};
    if (x >= s) return s + (((x - s) * a) >> 16);
    return s - (((s - x) * a) >> 16);
  endfunction

  function automatic logic [63:0] di_pct(logic [63:0] dm, logic [63:0] tr);
    logic [63:0] q;
    if (tr == 0) return 0;
    if (dm >= tr) return PCT_FULL;
    q = (dm * PCT_FULL) / tr;
    return (q > PCT_FULL) ? PCT_FULL : q;
  endfunction

  function automatic logic [63:0] dx_pct(logic [63:0] p, logic [63:0] m);
    logic [63:0] sum, diff;
    sum  = p + m;
    diff = (p > m) ? p - m : m - p;
    if (sum == 0) return 0;
    return (diff * PCT_FULL) / sum;
  endfunction

  // advance the indicator by one bar and return the reading it gives
  function automatic reading_t adx_advance(logic [63:0] h, logic [63:0] l, logic [63:0] c,
                                           logic start);
    longint d1, d2, d3, up, dn;
    logic [63:0] n, b, tr, pdm, mdm, t, p, m, dx;
    reading_t r;
    r = '0;
    n = {55'd0, period_reg};
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    if (start) begin
      prev_high  = h;
      prev_low   = l;
      prev_close = c;
      bar_idx    = '0;
      range_avg  = 0;
      plus_avg   = 0;
      minus_avg  = 0;
      dx_sum     = 0;
      adx_run    = 0;
      return r;
    end
    if (bar_idx < 10'd1023) bar_idx = bar_idx + 10'd1;
    b = {54'd0, bar_idx};
    // true range and directional movement
    d1 = longint'(h) - longint'(l);
    d2 = longint'(h) - longint'(prev_close);
    if (d2 < 0) d2 = -d2;
    d3 = longint'(l) - longint'(prev_close);
    if (d3 < 0) d3 = -d3;
    if (d2 > d1) d1 = d2;
    if (d3 > d1) d1 = d3;
    tr  = 64'(d1);
    up  = longint'(h) - longint'(prev_high);
    dn  = longint'(prev_low) - longint'(l);
    pdm = (up > dn && up > 0) ? 64'(up) : 0;
    mdm = (dn > up && dn > 0) ? 64'(dn) : 0;
    prev_high  = h;
    prev_low   = l;
    prev_close = c;
    // simple sums up to bar n, then smoothing
    if (b <= n) begin
      range_avg = (range_avg + tr) & MASK48;
      plus_avg  = (plus_avg + pdm) & MASK48;
      minus_avg = (minus_avg + mdm) & MASK48;
      if (b == n) begin
        range_avg = ((range_avg << FRAC_BITS) / n) & MASK48;
        plus_avg  = ((plus_avg << FRAC_BITS) / n) & MASK48;
        minus_avg = ((minus_avg << FRAC_BITS) / n) & MASK48;
      end
    end else begin
      range_avg = ease(range_avg, tr << FRAC_BITS) & MASK48;
      plus_avg  = ease(plus_avg, pdm << FRAC_BITS) & MASK48;
      minus_avg = ease(minus_avg, mdm << FRAC_BITS) & MASK48;
    end
    // di, dx and adx
    if (b >= n) begin
      t = range_avg;
      p = plus_avg;
      m = minus_avg;
      while (t >= WIDE_TR) begin
        t = t >> 1;
        p = p >> 1;
        m = m >> 1;
      end
      r.plus_di  = OUT_BITS'(di_pct(p, t));
      r.minus_di = OUT_BITS'(di_pct(m, t));
      r.di_ok    = 1'b1;
      dx = dx_pct({41'd0, r.plus_di}, {41'd0, r.minus_di});
      if (b <= 2 * n - 2) begin
        dx_sum = dx_sum + dx[31:0];
      end else begin
        if (b == 2 * n - 1) adx_run = ({32'd0, dx_sum} / (n - 1)) & MASK23;
        else adx_run = ease(adx_run, dx) & MASK23;
        r.adx_ok = 1'b1;
        r.adx    = OUT_BITS'(adx_run);
      end
    end
    return r;
  endfunction

  // watch config writes, requests and results
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      period_reg = PERIOD_RESET;
      alpha_reg  = ALPHA_RESET;
      prev_high  = 0;
      prev_low   = 0;
      prev_close = 0;
      bar_idx    = '0;
      range_avg  = 0;
      plus_avg   = 0;
      minus_avg  = 0;
      dx_sum     = 0;
      adx_run    = 0;
      errors_o   = 0;
      due_readings.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_PERIOD) period_reg = cfg_data_i[PERIOD_BITS-1:0];
        else if (cfg_index_i == CFG_ALPHA) alpha_reg = cfg_data_i[ALPHA_BITS-1:0];
      end
      if (in_valid_i && in_ready_i)
        due_readings.push_back(adx_advance({32'd0, high_price_i}, {32'd0, low_price_i},
                                           {32'd0, close_price_i}, series_start_i));
      if (out_valid_i && out_ready_i) begin
        if (due_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h %h %h %b %b", $time,
                   plus_di_i, minus_di_i, adx_value_i, di_valid_i, adx_valid_i);
          errors_o = errors_o + 1;
        end else begin
          want = due_readings.pop_front();
          if (plus_di_i !== want.plus_di) begin
            $display("%0t: plus_di expected %h actual %h", $time, want.plus_di, plus_di_i);
            errors_o = errors_o + 1;
          end
          if (minus_di_i !== want.minus_di) begin
            $display("%0t: minus_di expected %h actual %h", $time, want.minus_di, minus_di_i);
            errors_o = errors_o + 1;
          end
          if (adx_value_i !== want.adx) begin
            $display("%0t: adx_value expected %h actual %h", $time, want.adx, adx_value_i);
            errors_o = errors_o + 1;
          end
          if (di_valid_i !== want.di_ok) begin
            $display("%0t: di_valid expected %b actual %b", $time, want.di_ok, di_valid_i);
            errors_o = errors_o + 1;
          end
          if (adx_valid_i !== want.adx_ok) begin
            $display("%0t: adx_valid expected %b actual %b", $time, want.adx_ok, adx_valid_i);
            errors_o = errors_o + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_directional_movement_index_top.sv -----
// ----------------------------------------------------------------------------
// tb_directional_movement_index_top
// Drives price bars into the adx block under several period and alpha
// settings, with random gaps and result stalls; the checker beside the
// block predicts every reading and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_directional_movement_index_top import dmi_pkg::*;;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [PRICE_BITS-1:0]    high_price_i;
  logic [PRICE_BITS-1:0]    low_price_i;
  logic [PRICE_BITS-1:0]    close_price_i;
  logic                     series_start_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [OUT_BITS-1:0]      plus_di_o;
  logic [OUT_BITS-1:0]      minus_di_o;
  logic [OUT_BITS-1:0]      adx_value_o;
  logic                     di_valid_o;
  logic                     adx_valid_o;

  int   mismatches;
  int   readings_due;
  logic quiet;
  int   ready_hold;
  logic [31:0] base_price;

  always #1 clk_i = ~clk_i;

  directional_movement_index_top dut (.*);

  dmi_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .high_price_i, .low_price_i, .close_price_i, .series_start_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .plus_di_i(plus_di_o), .minus_di_i(minus_di_o), .adx_value_i(adx_value_o),
    .di_valid_i(di_valid_o), .adx_valid_i(adx_valid_o),
    .errors_o(mismatches), .pending_o(readings_due)
  );

  // result side: bursts of ready and stall, always ready once quiet
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_hold  <= 0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 2) != 0);
      ready_hold  <= $urandom_range(1, 14) - 1;
    end
  end

  // present one bar and hold it until taken
  task automatic send_bar(logic [31:0] h, logic [31:0] l, logic [31:0] c, logic start);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    high_price_i   <= h;
    low_price_i    <= l;
    close_price_i  <= c;
    series_start_i <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // random bar: mostly a walk around a base price, some noise and extremes
  task automatic random_bar(logic start);
    logic [31:0] h, l, c;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      if ($urandom_range(0, 7) == 0) base_price = $urandom_range(32'hFFFF_E000, 2000);
      else base_price = base_price + $urandom_range(0, 600) - 300;
      if (base_price < 2000 || base_price > 32'hFFFF_E000) base_price = 32'd100000;
      h = base_price + $urandom_range(0, 800);
      l = base_price - $urandom_range(0, 800);
      c = $urandom_range(h, l);
    end else if (pick < 9) begin
      h = $urandom;
      l = $urandom;
      c = $urandom;
    end else begin
      h = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      l = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      c = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    end
    send_bar(h, l, c, start);
  endtask

  // series of random length around the adx warm-up, with stray series starts
  task automatic run_series(int count, int span, logic one_series);
    int left;
    logic start;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (one_series) start = (i == 0);
      else start = (left == 0) || ($urandom_range(0, 59) == 0);
      if (start) left = $urandom_range(1, 2 * span + 8);
      else if (left > 0) left--;
      random_bar(start);
    end
  endtask

  // register write once every reading has come out
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (readings_due != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_DATA_BITS-1:0] per, logic [CFG_DATA_BITS-1:0] alf);
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_ALPHA, alf);
  endtask

  // stimulus
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_PERIOD;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    high_price_i   = '0;
    low_price_i    = '0;
    close_price_i  = '0;
    series_start_i = 1'b0;
    quiet          = 1'b0;
    base_price     = 32'd100000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: first bar without a series start, then extreme swings
    send_bar(32'd100, 32'd90, 32'd95, 1'b0);
    send_bar(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1);
    send_bar(32'd7, 32'd7, 32'd7, 1'b0);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_bar(32'd0, 32'd0, 32'd0, 1'b0);
    for (int i = 0; i < 16; i++)
      send_bar(i[0] ? 32'hFFFF_FFFF : 32'd500 + i, i[0] ? 32'hFFFF_0000 : 32'd0,
               32'h8000_0000, 1'b0);

    // shortest period, largest alpha; a flat series gives zero range
    set_regs(16'd2, 16'hFFFF);
    send_bar(32'd50, 32'd50, 32'd50, 1'b1);
    for (int i = 0; i < 5; i++) send_bar(32'd50, 32'd50, 32'd50, 1'b0);
    run_series(50, 2, 1'b0);

    // ema form and wilder form
    set_regs(16'd5, 16'd21845);
    run_series(50, 5, 1'b0);
    set_regs(16'd14, 16'd4681);
    run_series(50, 14, 1'b0);

    // period changed between series
    write_reg(CFG_PERIOD, 16'd3);
    run_series(20, 3, 1'b1);
    write_reg(CFG_PERIOD, 16'd9);
    run_series(20, 9, 1'b0);

    // longest period with a small alpha
    set_regs(16'd256, 16'd256);
    run_series(520, 256, 1'b1);

    // clamped periods and frozen smoothing
    set_regs(16'd1, 16'd0);
    run_series(20, 2, 1'b0);
    set_regs(16'd0, 16'd1);
    run_series(20, 2, 1'b0);
    set_regs(16'd300, 16'd32768);
    run_series(20, 4, 1'b0);

    // last stretch with no idling on either side
    set_regs(16'd3, 16'd21845);
    quiet = 1'b1;
    run_series(30, 3, 1'b1);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (readings_due != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_directional_movement_index_top: done, clean");
    else
      $display("tb_directional_movement_index_top: done, errors");
    $finish;
  end

  // run time limit
  initial begin
    #10_000_000;
    $display("tb_directional_movement_index_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
